FILE: src/bptb_pkg.sv
// Package: verb codes, widths and sequencer states for the path bounds block.
package bptb_pkg;

  localparam int CoordW = 32;
  localparam int VerbW  = 3;

  typedef enum logic [VerbW-1:0] {
    VERB_MOVE  = 3'd0,
    VERB_LINE  = 3'd1,
    VERB_QUAD  = 3'd2,
    VERB_CUBIC = 3'd3,
    VERB_CLOSE = 3'd4
  } verb_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_AXIS,
    ST_SQRT,
    ST_CAND,
    ST_DIV,
    ST_LERP,
    ST_NEXT,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_THIRD,
    T_CURVE,
    T_WAIT,
    T_FIN
  } top_state_t;

  localparam logic signed [CoordW-1:0] MinReset = 32'sh7FFF_FFFF;
  localparam logic signed [CoordW-1:0] MaxReset = 32'sh8000_0000;

endpackage

FILE: src/bezier_path_tight_bounds.sv
// Top level: path verb intake, quad raising, running box and result register.
// One verb is taken at a time. Move, line and close pass through the final state
// before the next transfer. A quad or cubic runs both axes in parallel through a
// bit-serial engine: two 34-step multiplies, a 34-step square root, then up to
// three candidates, each taking a serial divide and six serial lerps. The quad's
// 2/3 control points add a serial divide by three first. The box result is
// held in an output register; later verbs keep flowing while it waits, and only
// the next end-of-path verb holds in its final cycle until that register is free.
module bezier_path_tight_bounds (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bptb_pkg::VerbW-1:0]         in_req_type,
  input  logic signed [bptb_pkg::CoordW-1:0] in_pt1_x,
  input  logic signed [bptb_pkg::CoordW-1:0] in_pt1_y,
  input  logic signed [bptb_pkg::CoordW-1:0] in_pt2_x,
  input  logic signed [bptb_pkg::CoordW-1:0] in_pt2_y,
  input  logic signed [bptb_pkg::CoordW-1:0] in_pt3_x,
  input  logic signed [bptb_pkg::CoordW-1:0] in_pt3_y,
  input  logic                               in_end_of_path,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [bptb_pkg::CoordW-1:0] out_box_min_x,
  output logic signed [bptb_pkg::CoordW-1:0] out_box_min_y,
  output logic signed [bptb_pkg::CoordW-1:0] out_box_max_x,
  output logic signed [bptb_pkg::CoordW-1:0] out_box_max_y,
  output logic                               out_box_empty
);
  import bptb_pkg::*;

  top_state_t st_r, st_nxt;
  logic [VerbW-1:0] verb_r;
  logic eop_r;
  logic signed [CoordW-1:0] cur_x_r, cur_y_r, mnx_r, mny_r, mxx_r, mxy_r;
  logic signed [CoordW-1:0] p1x_r, p1y_r, p2x_r, p2y_r, p3x_r, p3y_r;
  logic ovalid_r;
  logic [5:0] cnt_r;
  logic wx_done_r, wy_done_r;

  // four serial divide-by-3 units: c1x, c1y, c2x, c2y (numerator magnitude 35 bits)
  logic [34:0] tn_r [4];
  logic [1:0]  trem_r [4];
  logic [34:0] tq_r [4];
  logic        tneg_r [4];
  logic signed [CoordW-1:0] tbase_r [4];

  logic signed [CoordW-1:0] ax_mn, ax_mx, ay_mn, ay_mx;
  logic ax_done, ay_done, start_c;
  logic signed [CoordW-1:0] c1x_c, c2x_c, c1y_c, c2y_c, ex_c, ey_c;
  logic signed [CoordW-1:0] third_c [4];
  logic in_fire;
  logic fin_go_c;

  assign in_ready = (st_r == T_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign start_c  = (st_r == T_CURVE);
  // final cycle may leave unless it has a box to load and the output is still full
  assign fin_go_c = !eop_r || !ovalid_r || out_ready;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      // floor for q>=0, -ceil(|q|/3) for q<0
      third_c[i] = CoordW'(36'(tbase_r[i]) +
                   (tneg_r[i] ? -36'(tq_r[i]) - 36'(trem_r[i] != 0) : 36'(tq_r[i])));
    end
    if (verb_r == VERB_QUAD) begin
      c1x_c = third_c[0]; c1y_c = third_c[1];
      c2x_c = third_c[2]; c2y_c = third_c[3];
      ex_c = p2x_r; ey_c = p2y_r;
    end else begin
      c1x_c = p1x_r; c1y_c = p1y_r;
      c2x_c = p2x_r; c2y_c = p2y_r;
      ex_c = p3x_r; ey_c = p3y_r;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      T_IDLE: if (in_fire) begin
        if (in_req_type == VERB_QUAD) st_nxt = T_THIRD;
        else if (in_req_type == VERB_CUBIC) st_nxt = T_CURVE;
        else st_nxt = T_FIN;
      end
      T_THIRD: if (cnt_r == 0) st_nxt = T_CURVE;
      T_CURVE: st_nxt = T_WAIT;
      T_WAIT:  if ((wx_done_r || ax_done) && (wy_done_r || ay_done)) st_nxt = T_FIN;
      T_FIN:   if (fin_go_c) st_nxt = T_IDLE;
      default: st_nxt = T_IDLE;
    endcase
  end

  bptb_axis u_ax (
    .clk(clk), .rst_n(rst_n), .start(start_c),
    .s_i(cur_x_r), .c1_i(c1x_c), .c2_i(c2x_c), .e_i(ex_c),
    .mn_i(mnx_r), .mx_i(mxx_r), .mn_o(ax_mn), .mx_o(ax_mx), .done(ax_done)
  );
  bptb_axis u_ay (
    .clk(clk), .rst_n(rst_n), .start(start_c),
    .s_i(cur_y_r), .c1_i(c1y_c), .c2_i(c2y_c), .e_i(ey_c),
    .mn_i(mny_r), .mx_i(mxy_r), .mn_o(ay_mn), .mx_o(ay_mx), .done(ay_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= T_IDLE; ovalid_r <= 1'b0;
      cur_x_r <= '0; cur_y_r <= '0;
      mnx_r <= MinReset; mny_r <= MinReset; mxx_r <= MaxReset; mxy_r <= MaxReset;
      wx_done_r <= 1'b0; wy_done_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == T_FIN && eop_r && fin_go_c) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
      case (st_r)
        T_IDLE: if (in_fire) begin
          verb_r <= in_req_type; eop_r <= in_end_of_path;
          p1x_r <= in_pt1_x; p1y_r <= in_pt1_y; p2x_r <= in_pt2_x;
          p2y_r <= in_pt2_y; p3x_r <= in_pt3_x; p3y_r <= in_pt3_y;
          wx_done_r <= 1'b0; wy_done_r <= 1'b0;
          cnt_r <= 6'd35;
          if (in_req_type == VERB_MOVE || in_req_type == VERB_LINE) begin
            if (in_pt1_x < mnx_r) mnx_r <= in_pt1_x;
            if (in_pt1_x > mxx_r) mxx_r <= in_pt1_x;
            if (in_pt1_y < mny_r) mny_r <= in_pt1_y;
            if (in_pt1_y > mxy_r) mxy_r <= in_pt1_y;
            cur_x_r <= in_pt1_x; cur_y_r <= in_pt1_y;
          end
        end
        T_THIRD: if (cnt_r != 0) cnt_r <= cnt_r - 6'd1;
        T_WAIT: begin
          if (ax_done) begin mnx_r <= ax_mn; mxx_r <= ax_mx; wx_done_r <= 1'b1; end
          if (ay_done) begin mny_r <= ay_mn; mxy_r <= ay_mx; wy_done_r <= 1'b1; end
          if (st_nxt == T_FIN) begin
            cur_x_r <= ex_c; cur_y_r <= ey_c;
          end
        end
        T_FIN: if (eop_r && fin_go_c) begin
          out_box_min_x <= mnx_r; out_box_min_y <= mny_r;
          out_box_max_x <= mxx_r; out_box_max_y <= mxy_r;
          out_box_empty <= (mnx_r > mxx_r);
          mnx_r <= MinReset; mny_r <= MinReset; mxx_r <= MaxReset; mxy_r <= MaxReset;
        end
        default: ;
      endcase
    end
  end

  // serial restoring divide by three, one numerator bit per cycle
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      logic signed [35:0] q;
      logic [2:0] r2;
      q = '0; r2 = '0;
      if (st_r == T_IDLE && in_fire) begin
        case (i)
          0: begin q = 2 * (36'(in_pt1_x) - 36'(cur_x_r)) + 36'sd1; tbase_r[i] <= cur_x_r; end
          1: begin q = 2 * (36'(in_pt1_y) - 36'(cur_y_r)) + 36'sd1; tbase_r[i] <= cur_y_r; end
          2: begin q = 2 * (36'(in_pt1_x) - 36'(in_pt2_x)) + 36'sd1; tbase_r[i] <= in_pt2_x; end
          default: begin
            q = 2 * (36'(in_pt1_y) - 36'(in_pt2_y)) + 36'sd1; tbase_r[i] <= in_pt2_y;
          end
        endcase
        tneg_r[i] <= q[35];
        tn_r[i] <= q[35] ? 35'(-q) : 35'(q);
        trem_r[i] <= '0; tq_r[i] <= '0;
      end else if (st_r == T_THIRD && cnt_r != 0) begin
        r2 = {trem_r[i], tn_r[i][34]};
        tn_r[i] <= tn_r[i] << 1;
        if (r2 >= 3'd3) begin
          trem_r[i] <= 2'(r2 - 3'd3); tq_r[i] <= {tq_r[i][33:0], 1'b1};
        end else begin
          trem_r[i] <= 2'(r2); tq_r[i] <= {tq_r[i][33:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = ovalid_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != T_IDLE) |-> !in_ready) else $error("input taken while busy");
  a_emit_eop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> $past(eop_r)) else $error("result without end of path");
  a_box_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> (mnx_r == MinReset && mxx_r == MaxReset))
    else $error("box not cleared after emit");
endmodule

FILE: src/bptb_axis.sv
// Per-axis extremum engine: square root, division and lerps done one bit per cycle.
module bptb_axis (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [bptb_pkg::CoordW-1:0]    s_i,
  input  logic signed [bptb_pkg::CoordW-1:0]    c1_i,
  input  logic signed [bptb_pkg::CoordW-1:0]    c2_i,
  input  logic signed [bptb_pkg::CoordW-1:0]    e_i,
  input  logic signed [bptb_pkg::CoordW-1:0]    mn_i,
  input  logic signed [bptb_pkg::CoordW-1:0]    mx_i,
  output logic signed [bptb_pkg::CoordW-1:0]    mn_o,
  output logic signed [bptb_pkg::CoordW-1:0]    mx_o,
  output logic                                  done
);
  import bptb_pkg::*;

  // Differences and D are held in 35 bits, B*B-A*C in 68.
  logic signed [34:0] a_r, b_r, c_r, d_r;
  logic signed [34:0] a_nxt, b_nxt, c_nxt, d_nxt;
  logic signed [CoordW-1:0] s_r, c1_r, c2_r, e_r, mn_r, mx_r;
  logic signed [CoordW-1:0] mn_nxt, mx_nxt;
  state_t st_r, st_nxt;

  // discriminant by shift-add multiply, then sqrt
  logic [67:0] disc_r, disc_nxt;
  logic [67:0] rem_r, rem_nxt;
  logic [33:0] root_r, root_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [1:0]  cand_r, cand_nxt;   // 0:+r 1:-r 2:plain
  logic        real_r, real_nxt;
  logic        mulph_r, mulph_nxt;
  logic [67:0] macc_r, macc_nxt;
  logic [33:0] mca_r, mca_nxt;    // multiplier shift register
  logic [67:0] mcb_r, mcb_nxt;    // multiplicand shift register

  // divider
  logic [36:0] dn_r, dn_nxt, dd_r, dd_nxt, dr_r, dr_nxt;
  logic [31:0] q_r, q_nxt;
  logic [31:0] t_r, t_nxt;

  // lerp: serial multiply of 36-bit diff by 32-bit t
  logic [2:0]  lstep_r, lstep_nxt;
  logic signed [CoordW-1:0] l1_r, l2_r, l3_r, m1_r, m2_r;
  logic signed [CoordW-1:0] l1_nxt, l2_nxt, l3_nxt, m1_nxt, m2_nxt;
  logic signed [68:0] lacc_r, lacc_nxt;
  logic [31:0] lt_r, lt_nxt;

  logic signed [35:0] num_c, den_c;
  logic signed [CoordW-1:0] lp_c, lq_c, lres_c;
  logic signed [35:0] ldiff_c;
  logic signed [68:0] lsum_c;
  logic [67:0] trial_c;
  logic [36:0] dsh_c;
  logic cand_ok_c;

  always_comb begin
    num_c = 36'(a_r - b_r);
    den_c = 36'(d_r);
    if (d_r == '0) begin
      num_c = 36'(2 * b_r - c_r);
      den_c = 36'(2 * (b_r - c_r));
    end else if (cand_r == 2'd0) begin
      num_c = 36'(a_r - b_r) + 36'($signed({2'b0, root_r}));
    end else if (cand_r == 2'd1) begin
      num_c = 36'(a_r - b_r) - 36'($signed({2'b0, root_r}));
    end
    cand_ok_c = (num_c >= 0 && den_c > 0 && num_c <= den_c) ||
                (num_c <= 0 && den_c < 0 && num_c >= den_c);
  end

  always_comb begin
    case (lstep_r)
      3'd0: begin lp_c = s_r;  lq_c = c1_r; end
      3'd1: begin lp_c = c1_r; lq_c = c2_r; end
      3'd2: begin lp_c = c2_r; lq_c = e_r;  end
      3'd3: begin lp_c = l1_r; lq_c = l2_r; end
      3'd4: begin lp_c = l2_r; lq_c = l3_r; end
      default: begin lp_c = m1_r; lq_c = m2_r; end
    endcase
    ldiff_c = 36'(lq_c) - 36'(lp_c);
    lsum_c  = lacc_r + 69'sd1073741824;
    lres_c  = CoordW'(69'(lp_c) + (lsum_c >>> 31));
    trial_c = (68'(root_r) << (cnt_r[5:0] + 6'd1)) | (68'd1 << (2 * cnt_r[5:0]));
    dsh_c   = {dr_r[35:0], 1'b0};
  end

  always_comb begin
    st_nxt = st_r; a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r;
    mn_nxt = mn_r; mx_nxt = mx_r; disc_nxt = disc_r; rem_nxt = rem_r;
    root_nxt = root_r; cnt_nxt = cnt_r; cand_nxt = cand_r; real_nxt = real_r;
    mulph_nxt = mulph_r; macc_nxt = macc_r; mca_nxt = mca_r; mcb_nxt = mcb_r;
    dn_nxt = dn_r; dd_nxt = dd_r; dr_nxt = dr_r; q_nxt = q_r; t_nxt = t_r;
    lstep_nxt = lstep_r; l1_nxt = l1_r; l2_nxt = l2_r; l3_nxt = l3_r;
    m1_nxt = m1_r; m2_nxt = m2_r; lacc_nxt = lacc_r; lt_nxt = lt_r;
    case (st_r)
      ST_IDLE: if (start) begin
        a_nxt = 35'(c1_i) - 35'(s_i);
        b_nxt = 35'(c2_i) - 35'(c1_i);
        c_nxt = 35'(e_i) - 35'(c2_i);
        mn_nxt = (s_i < mn_i) ? s_i : mn_i;
        mx_nxt = (s_i > mx_i) ? s_i : mx_i;
        st_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        d_nxt = a_r - 2 * b_r + c_r;
        if (e_r < mn_r) mn_nxt = e_r;
        if (e_r > mx_r) mx_nxt = e_r;
        // B*B first
        macc_nxt = '0; mca_nxt = b_r[34] ? 34'(-b_r) : 34'(b_r);
        mcb_nxt = 68'(b_r[34] ? 35'(-b_r) : b_r);
        mulph_nxt = 1'b0; cnt_nxt = 7'd34;
        st_nxt = ST_AXIS;
      end
      ST_AXIS: begin
        // one multiplier bit per cycle; phase 0 B*B, phase 1 A*C
        if (cnt_r != 0) begin
          if (mca_r[0]) macc_nxt = macc_r + mcb_r;
          mca_nxt = mca_r >> 1; mcb_nxt = mcb_r << 1; cnt_nxt = cnt_r - 7'd1;
        end else if (!mulph_r) begin
          disc_nxt = macc_r; macc_nxt = '0; mulph_nxt = 1'b1; cnt_nxt = 7'd34;
          mca_nxt = a_r[34] ? 34'(-a_r) : 34'(a_r);
          mcb_nxt = 68'(c_r[34] ? 35'(-c_r) : c_r);
        end else begin
          // sign of A*C
          if ((a_r[34] != c_r[34]) && a_r != 0 && c_r != 0) begin
            disc_nxt = disc_r + macc_r; real_nxt = 1'b1;
          end else if (macc_r > disc_r) begin
            real_nxt = 1'b0;
          end else begin
            disc_nxt = disc_r - macc_r; real_nxt = 1'b1;
          end
          rem_nxt = '0; root_nxt = '0; cnt_nxt = 7'd33;
          if (d_r == 0) begin
            cand_nxt = 2'd2;
            st_nxt = (b_r != c_r) ? ST_CAND : ST_NEXT;
          end else begin
            cand_nxt = real_nxt ? 2'd0 : 2'd2;
            st_nxt = real_nxt ? ST_SQRT : ST_CAND;
          end
        end
      end
      ST_SQRT: begin
        // restoring bitwise sqrt: rem holds root^2
        if (rem_r + trial_c <= disc_r) begin
          rem_nxt = rem_r + trial_c;
          root_nxt = root_r | (34'd1 << cnt_r[5:0]);
        end
        if (cnt_r == 0) st_nxt = ST_CAND;
        else cnt_nxt = cnt_r - 7'd1;
      end
      ST_CAND: begin
        if (cand_ok_c) begin
          dn_nxt = num_c[35] ? 37'(-num_c) : 37'(num_c);
          dd_nxt = den_c[35] ? 37'(-den_c) : 37'(den_c);
          dr_nxt = num_c[35] ? 37'(-num_c) : 37'(num_c);
          q_nxt = '0; cnt_nxt = 7'd31;
          st_nxt = ST_DIV;
        end else begin
          st_nxt = ST_NEXT;
        end
      end
      ST_DIV: begin
        if (dn_r >= dd_r) begin
          t_nxt = 32'h8000_0000;
          st_nxt = ST_LERP; lstep_nxt = '0; lacc_nxt = '0; lt_nxt = 32'h8000_0000;
          cnt_nxt = 7'd32;
        end else if (cnt_r != 0) begin
          if (dsh_c >= dd_r) begin
            dr_nxt = dsh_c - dd_r; q_nxt = {q_r[30:0], 1'b1};
          end else begin
            dr_nxt = dsh_c; q_nxt = {q_r[30:0], 1'b0};
          end
          cnt_nxt = cnt_r - 7'd1;
        end else begin
          t_nxt = ({dr_r[35:0], 1'b0} >= dd_r) ? q_r + 32'd1 : q_r;
          lt_nxt = t_nxt;
          st_nxt = ST_LERP; lstep_nxt = '0; lacc_nxt = '0; cnt_nxt = 7'd32;
        end
      end
      ST_LERP: begin
        // diff * t, one bit of t per cycle from the top
        if (cnt_r != 0) begin
          lacc_nxt = (lacc_r <<< 1) + (lt_r[31] ? 69'(ldiff_c) : 69'sd0);
          lt_nxt = lt_r << 1;
          cnt_nxt = cnt_r - 7'd1;
        end else begin
          case (lstep_r)
            3'd0: l1_nxt = lres_c;
            3'd1: l2_nxt = lres_c;
            3'd2: l3_nxt = lres_c;
            3'd3: m1_nxt = lres_c;
            3'd4: m2_nxt = lres_c;
            default: begin
              if (lres_c < mn_r) mn_nxt = lres_c;
              if (lres_c > mx_r) mx_nxt = lres_c;
            end
          endcase
          lacc_nxt = '0; lt_nxt = t_r; cnt_nxt = 7'd32;
          if (lstep_r == 3'd5) st_nxt = ST_NEXT;
          else lstep_nxt = lstep_r + 3'd1;
        end
      end
      ST_NEXT: begin
        if (cand_r == 2'd2) st_nxt = ST_EMIT;
        else begin
          cand_nxt = cand_r + 2'd1;
          st_nxt = ST_CAND;
        end
      end
      ST_EMIT: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt; d_r <= d_nxt;
    if (st_r == ST_IDLE && start) begin
      s_r <= s_i; c1_r <= c1_i; c2_r <= c2_i; e_r <= e_i;
    end
    mn_r <= mn_nxt; mx_r <= mx_nxt; disc_r <= disc_nxt; rem_r <= rem_nxt;
    root_r <= root_nxt; cnt_r <= cnt_nxt; cand_r <= cand_nxt; real_r <= real_nxt;
    mulph_r <= mulph_nxt; macc_r <= macc_nxt; mca_r <= mca_nxt; mcb_r <= mcb_nxt;
    dn_r <= dn_nxt; dd_r <= dd_nxt; dr_r <= dr_nxt; q_r <= q_nxt; t_r <= t_nxt;
    lstep_r <= lstep_nxt; l1_r <= l1_nxt; l2_r <= l2_nxt; l3_r <= l3_nxt;
    m1_r <= m1_nxt; m2_r <= m2_nxt; lacc_r <= lacc_nxt; lt_r <= lt_nxt;
  end

  assign mn_o = mn_r;
  assign mx_o = mx_r;
  assign done = (st_r == ST_EMIT);

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("done held");
  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> mn_r <= mx_r) else $error("axis box inverted after segment");
  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_LERP) |-> t_r <= 32'h8000_0000) else $error("t out of range");
endmodule

FILE: tb/sv/bezier_path_tight_bounds_tb.sv
// Testbench for bezier_path_tight_bounds: random path stimulus, box predictor and scoreboard.
module bezier_path_tight_bounds_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bptb_pkg::*;

  localparam longint HalfQ31 = 64'sd1073741824;
  localparam longint OneQ31  = 64'sd2147483648;

  // One path verb as driven on the input channel.
  typedef struct {
    logic [VerbW-1:0] verb;
    int               x1, y1, x2, y2, x3, y3;
    bit               eop;
  } verb_item_t;

  // One bounding box as seen on the result channel.
  typedef struct {
    int min_x, min_y, max_x, max_y;
    bit empty;
  } box_t;

  // Tracks the path state and holds the boxes still due from the block.
  class box_scoreboard;
    int   cur_x, cur_y, lo_x, lo_y, hi_x, hi_y;
    box_t due_boxes[$];

    function new();
      cur_x = 0;
      cur_y = 0;
      clear_box();
    endfunction

    function void clear_box();
      lo_x = MinReset;
      lo_y = MinReset;
      hi_x = MaxReset;
      hi_y = MaxReset;
    endfunction

    function int pending();
      return due_boxes.size();
    endfunction

    function void widen(input int v, inout int lo, inout int hi);
      if (v < lo) lo = v;
      if (v > hi) hi = v;
    endfunction

    // p + floor(((q - p) * t + 2^30) / 2^31)
    function int lerp(input int p, input int q, input longint t);
      longint d;
      d = longint'(q) - longint'(p);
      return int'(longint'(p) + ((d * t + HalfQ31) >>> 31));
    endfunction

    // Quad control point, 2/3 of the way from p0 toward p1, rounded.
    function int two_thirds(input int p0, input int p1);
      longint q, f;
      q = 2 * (longint'(p1) - longint'(p0)) + 1;
      f = (q >= 0) ? q / 3 : -((-q + 2) / 3);
      return int'(longint'(p0) + f);
    endfunction

    function longint root_floor(input logic [127:0] v);
      logic [63:0]  r, c;
      logic [127:0] sq;
      r = 0;
      for (int b = 33; b >= 0; b--) begin
        c  = r | (64'd1 << b);
        sq = {64'd0, c} * {64'd0, c};
        if (sq <= v) r = c;
      end
      return longint'(r);
    endfunction

    // Evaluate the curve at num/den when that lies in [0, 1].
    function void try_t(input longint num, input longint den, input int s, input int c1,
                        input int c2, input int e, inout int lo, inout int hi);
      logic [63:0]  n, d;
      logic [127:0] scaled, q, rem;
      longint       t;
      int           l1, l2, l3, m1, m2;
      if (!((num >= 0 && den > 0 && num <= den) || (num <= 0 && den < 0 && num >= den)))
        return;
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      if (n >= d) begin
        t = OneQ31;
      end else begin
        scaled = {64'd0, n} << 31;
        q      = scaled / {64'd0, d};
        rem    = scaled % {64'd0, d};
        if ((rem << 1) >= {64'd0, d}) q++;
        t = longint'(q[63:0]);
      end
      l1 = lerp(s, c1, t);
      l2 = lerp(c1, c2, t);
      l3 = lerp(c2, e, t);
      m1 = lerp(l1, l2, t);
      m2 = lerp(l2, l3, t);
      widen(lerp(m1, m2, t), lo, hi);
    endfunction

    function void cubic_axis(input int s, input int c1, input int c2, input int e,
                             inout int lo, inout int hi);
      longint a, b, c, d, rt;
      logic signed [127:0] aw, bw, cw, disc;
      a = longint'(c1) - s;
      b = longint'(c2) - c1;
      c = longint'(e) - c2;
      d = a - 2 * b + c;
      widen(s, lo, hi);
      widen(e, lo, hi);
      if (d != 0) begin
        aw   = a;
        bw   = b;
        cw   = c;
        disc = bw * bw - aw * cw;
        if (disc >= 0) begin
          rt = root_floor(disc);
          try_t(a - b + rt, d, s, c1, c2, e, lo, hi);
          try_t(a - b - rt, d, s, c1, c2, e, lo, hi);
        end
        try_t(a - b, d, s, c1, c2, e, lo, hi);
      end else if (b != c) begin
        try_t(2 * b - c, 2 * (b - c), s, c1, c2, e, lo, hi);
      end
    endfunction

    // Accepted input: advance the path state, queue a box on end of path.
    function void note_verb(input verb_item_t it);
      box_t bx;
      case (it.verb)
        VERB_MOVE, VERB_LINE: begin
          widen(it.x1, lo_x, hi_x);
          widen(it.y1, lo_y, hi_y);
          cur_x = it.x1;
          cur_y = it.y1;
        end
        VERB_QUAD: begin
          cubic_axis(cur_x, two_thirds(cur_x, it.x1), two_thirds(it.x2, it.x1), it.x2,
                     lo_x, hi_x);
          cubic_axis(cur_y, two_thirds(cur_y, it.y1), two_thirds(it.y2, it.y1), it.y2,
                     lo_y, hi_y);
          cur_x = it.x2;
          cur_y = it.y2;
        end
        VERB_CUBIC: begin
          cubic_axis(cur_x, it.x1, it.x2, it.x3, lo_x, hi_x);
          cubic_axis(cur_y, it.y1, it.y2, it.y3, lo_y, hi_y);
          cur_x = it.x3;
          cur_y = it.y3;
        end
        default: ;
      endcase
      if (it.eop) begin
        bx.min_x = lo_x;
        bx.min_y = lo_y;
        bx.max_x = hi_x;
        bx.max_y = hi_y;
        bx.empty = (lo_x > hi_x);
        due_boxes = {due_boxes, bx};
        clear_box();
      end
    endfunction

    // Accepted result: returns a description of what differs, empty if all match.
    function string check_box(input box_t got);
      box_t  exp;
      string msg;
      if (due_boxes.size() == 0) return "box transfer with nothing expected";
      exp = due_boxes.pop_front();
      msg = "";
      if (got.min_x != exp.min_x)
        msg = {msg, $sformatf(" min_x %h/%h", got.min_x, exp.min_x)};
      if (got.min_y != exp.min_y)
        msg = {msg, $sformatf(" min_y %h/%h", got.min_y, exp.min_y)};
      if (got.max_x != exp.max_x)
        msg = {msg, $sformatf(" max_x %h/%h", got.max_x, exp.max_x)};
      if (got.max_y != exp.max_y)
        msg = {msg, $sformatf(" max_y %h/%h", got.max_y, exp.max_y)};
      if (got.empty != exp.empty)
        msg = {msg, $sformatf(" empty %0d/%0d", got.empty, exp.empty)};
      return msg;
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [VerbW-1:0]         in_req_type;
  logic signed [CoordW-1:0] in_pt1_x, in_pt1_y, in_pt2_x, in_pt2_y, in_pt3_x, in_pt3_y;
  logic                     in_end_of_path;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [CoordW-1:0] out_box_min_x, out_box_min_y, out_box_max_x, out_box_max_y;
  logic                     out_box_empty;

  box_scoreboard boxes;
  int            mismatches = 0;
  int            send_idle_pct = 0;  // chance per cycle that the sender sits out
  int            recv_stall_pct = 0; // chance per cycle that the receiver stalls
  int            hold_cycles = 0;    // long receiver hold-off, counted down below

  bezier_path_tight_bounds i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_pt1_x       (in_pt1_x),
    .in_pt1_y       (in_pt1_y),
    .in_pt2_x       (in_pt2_x),
    .in_pt2_y       (in_pt2_y),
    .in_pt3_x       (in_pt3_x),
    .in_pt3_y       (in_pt3_y),
    .in_end_of_path (in_end_of_path),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_box_min_x  (out_box_min_x),
    .out_box_min_y  (out_box_min_y),
    .out_box_max_x  (out_box_max_x),
    .out_box_max_y  (out_box_max_y),
    .out_box_empty  (out_box_empty)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report(input string msg);
    $display("MISMATCH at %0t:%0s", $realtime, msg);
    mismatches++;
  endtask

  // Receiver: ready changes on the falling edge; a hold-off wins over the random stall.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready = 1'b0;
      end else begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Result monitor: sampled on the rising edge, before the block updates.
  initial begin
    box_t  got;
    string diff;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.min_x = out_box_min_x;
        got.min_y = out_box_min_y;
        got.max_x = out_box_max_x;
        got.max_y = out_box_max_y;
        got.empty = out_box_empty;
        diff = boxes.check_box(got);
        if (diff != "") report(diff);
      end
    end
  end

  // Drive one verb from a falling edge and hold it until the transfer; ends on a falling edge.
  task automatic send_verb(input verb_item_t it);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid       = 1'b1;
    in_req_type    = it.verb;
    in_pt1_x       = it.x1;
    in_pt1_y       = it.y1;
    in_pt2_x       = it.x2;
    in_pt2_y       = it.y2;
    in_pt3_x       = it.x3;
    in_pt3_y       = it.y3;
    in_end_of_path = it.eop;
    do @(posedge clk); while (!in_ready);
    boxes.note_verb(it);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_pts(input logic [VerbW-1:0] v, input int x1, input int y1, input int x2,
                          input int y2, input int x3, input int y3, input bit eop);
    verb_item_t it;
    it.verb = v;
    it.x1 = x1; it.y1 = y1;
    it.x2 = x2; it.y2 = y2;
    it.x3 = x3; it.y3 = y3;
    it.eop = eop;
    send_verb(it);
  endtask

  task automatic drain();
    while (boxes.pending() != 0) @(negedge clk);
  endtask

  // Coordinates: full range, large, moderate, small, or an extreme value.
  function automatic int rand_coord();
    case ($urandom_range(9))
      0, 1:    return int'($urandom);
      2, 3, 4: return int'($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
      5, 6:    return int'($urandom_range(2047)) - 1024;
      7: begin
        case ($urandom_range(4))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return 0;
          3:       return -1;
          default: return 1;
        endcase
      end
      default: return int'($urandom_range(32'h3FFF_FFFF)) - 32'sh2000_0000;
    endcase
  endfunction

  function automatic verb_item_t rand_verb(input logic [VerbW-1:0] v, input bit eop);
    verb_item_t it;
    it.verb = v;
    it.x1 = rand_coord(); it.y1 = rand_coord();
    it.x2 = rand_coord(); it.y2 = rand_coord();
    it.x3 = rand_coord(); it.y3 = rand_coord();
    it.eop = eop;
    return it;
  endfunction

  // Any verb code, unused ones included.
  function automatic logic [VerbW-1:0] rand_verb_code();
    return VerbW'($urandom_range(7));
  endfunction

  // Mostly whole paths (move, segments, end marker), some pure noise verbs.
  // Returns the number of verbs sent.
  task automatic send_random_path(output int n);
    int segs;
    logic [VerbW-1:0] v;
    n = 0;
    if ($urandom_range(99) < 80) begin
      send_verb(rand_verb(VERB_MOVE, 1'b0));
      n++;
      segs = $urandom_range(1, 5);
      for (int i = 0; i < segs; i++) begin
        case ($urandom_range(9))
          0, 1:    v = VERB_LINE;
          2, 3, 4: v = VERB_QUAD;
          9:       v = ($urandom_range(3) == 0) ? VERB_MOVE : VERB_CLOSE;
          default: v = VERB_CUBIC;
        endcase
        send_verb(rand_verb(v, i == segs - 1));
        n++;
      end
    end else begin
      send_verb(rand_verb(rand_verb_code(), $urandom_range(3) == 0));
      n++;
    end
  endtask

  initial begin
    int sent, n;
    boxes          = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = VERB_CLOSE;
    in_pt1_x       = 0;
    in_pt1_y       = 0;
    in_pt2_x       = 0;
    in_pt2_y       = 0;
    in_pt3_x       = 0;
    in_pt3_y       = 0;
    in_end_of_path = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty box, segments with no move, extremes, degenerate curves.
    send_pts(VERB_CLOSE, 0, 0, 0, 0, 0, 0, 1'b1);
    send_pts(VERB_LINE, 100, -100, 7, 7, 7, 7, 1'b1);
    send_pts(VERB_CUBIC, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
             32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    send_pts(VERB_MOVE, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0, 0, 1'b0);
    send_pts(VERB_QUAD, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
             -1, -1, 1'b1);
    send_pts(VERB_MOVE, 0, 0, 0, 0, 0, 0, 1'b0);
    // Flat second difference (linear derivative) and a cubic with real roots on both axes.
    send_pts(VERB_CUBIC, 30, 10, 50, 20, 60, 30, 1'b0);
    send_pts(VERB_CUBIC, 61, 31, 62, 32, 63, 33, 1'b0);
    send_pts(VERB_CUBIC, 2000, -5000, -3000, 9000, 100, 1, 1'b0);
    send_pts(VERB_CLOSE, 5, 5, 5, 5, 5, 5, 1'b0);
    send_pts(3'd5, 9, 9, 9, 9, 9, 9, 1'b0);
    send_pts(3'd6, -9, -9, -9, -9, -9, -9, 1'b0);
    send_pts(3'd7, 1, 1, 1, 1, 1, 1, 1'b1);
    send_pts(VERB_QUAD, 65536, 65536, 0, 0, 0, 0, 1'b0);
    send_pts(VERB_CUBIC, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
             32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    send_pts(VERB_LINE, -1, -1, 0, 0, 0, 0, 1'b0);
    send_pts(VERB_MOVE, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0, 0, 1'b1);
    send_pts(3'd5, 0, 0, 0, 0, 0, 0, 1'b1);
    drain();

    // Random phases: free flow, idle sender, stalling receiver, both idling a little.
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      sent = 0;
      while (sent < 225) begin
        send_random_path(n);
        sent += n;
        // Long receiver hold-off while the sender keeps pushing short paths.
        if (ph == 0 && sent > 100 && sent <= 100 + n) begin
          hold_cycles = 4000;
          for (int k = 0; k < 8; k++) send_pts(VERB_LINE, k, -k, 0, 0, 0, 0, 1'b1);
          sent += 8;
        end
      end
      // Sender waits until every box has come back.
      drain();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (800) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
src/bptb_pkg.sv
src/bptb_axis.sv
src/bezier_path_tight_bounds.sv
tb/sv/bezier_path_tight_bounds_tb.sv
